@@ design/sorted_linked_list_set_assert.svh @@
// Assertion macros used by the checker file of the sorted set.
`ifndef SORTED_LINKED_LIST_SET_ASSERT_SVH
`define SORTED_LINKED_LIST_SET_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SLS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted set check failed");

// Next-cycle implication, disabled while reset is low.
`define SLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted set check failed");

`endif

@@ design/sls_pkg.sv @@
// Types and codes shared by the sorted linked-list set.
package sls_pkg;

  localparam int MODE_W   = 2;
  localparam int STATUS_W = 3;
  localparam int TAIL_W   = 16;

  localparam logic [TAIL_W-1:0] TAIL_RESET = 16'hFFFF;

  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_WALK,
    S_ACT,
    S_INS_LINK,
    S_DEL_RDN,
    S_DEL_FINDQ,
    S_DEL_WQ,
    S_DEL_WPRED,
    S_DEL_WP,
    S_EMIT
  } state_e;

  // Store access controls for one cycle.
  typedef struct packed {
    logic rd_en;
    logic key_we;
    logic nxt_we;
  } store_ctl_t;

endpackage

@@ design/sorted_linked_list_set.sv @@
// A request is rejected at once or walks up to count links, then makes up to three write steps.
// A delete that moves the last slot into the hole may walk the chain a second time.
// One item at a time; the result register frees the input side as soon as it is loaded.
// Throughput is set by the link walk, one memory read per step.
// Reset clears control, count and head link and sets tail_key to 0xFFFF; memories are
// not cleared, since only slots 1..count are ever read.
module sorted_linked_list_set
  import sls_pkg::*;
#(
  parameter int MAX_ENTRIES = 128,
  parameter int KEY_WIDTH   = 16,
  localparam int SlotW      = $clog2(MAX_ENTRIES + 1),
  localparam int InTdataW   = ((MODE_W + KEY_WIDTH + 7) / 8) * 8,
  localparam int OutW       = STATUS_W + 3 * SlotW,
  localparam int OutTdataW  = ((OutW + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [TAIL_W-1:0]    cfg_wdata_i,      // tail_key
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,     // mode, key
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata      // status, slot, pred_slot, count
);

  localparam int CmpW = (KEY_WIDTH > TAIL_W) ? KEY_WIDTH : TAIL_W;
  localparam logic [SlotW-1:0] MaxCnt = SlotW'(MAX_ENTRIES);

  state_e                state_q, state_d;
  logic [TAIL_W-1:0]     tail_q;
  logic [MODE_W-1:0]     mode_q, mode_d;
  logic [KEY_WIDTH-1:0]  key_q, key_d;
  logic [SlotW-1:0]      cnt_q, cnt_d;
  logic [SlotW-1:0]      idx_q, idx_d;     // predecessor during the walk
  logic [SlotW-1:0]      nx_q, nx_d;       // link of idx_q
  logic [SlotW-1:0]      lp_q, lp_d;       // link of the hit slot
  logic                  hit_q, hit_d;
  logic [KEY_WIDTH-1:0]  kn_q, kn_d;       // key of the last slot
  logic [SlotW-1:0]      ln_q, ln_d;       // link of the last slot
  logic [SlotW-1:0]      qa_q, qa_d;
  logic [SlotW-1:0]      q_q, q_d;         // slot that links to the last slot
  logic [STATUS_W-1:0]   stat_q, stat_d;
  logic [SlotW-1:0]      slot_q, slot_d;

  logic                  m_valid_q, m_valid_d;
  logic                  out_load;
  logic [STATUS_W-1:0]   out_status_q;
  logic [SlotW-1:0]      out_slot_q, out_pred_q, out_cnt_q;

  store_ctl_t            ctl;
  logic [SlotW-1:0]      raddr, waddr, nxt_wdata;
  logic [KEY_WIDTH-1:0]  key_wdata, key_rdata;
  logic [SlotW-1:0]      nxt_rdata, head;
  logic [SlotW-1:0]      cnt_inc;

  sls_store #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .raddr_i    (raddr),
    .waddr_i    (waddr),
    .key_wdata_i(key_wdata),
    .nxt_wdata_i(nxt_wdata),
    .key_rdata_o(key_rdata),
    .nxt_rdata_o(nxt_rdata),
    .head_o     (head)
  );

  assign cnt_inc = cnt_q + SlotW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q <= TAIL_RESET;
    end else if (cfg_we_i) begin
      tail_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    key_q  <= key_d;
    idx_q  <= idx_d;
    nx_q   <= nx_d;
    lp_q   <= lp_d;
    hit_q  <= hit_d;
    kn_q   <= kn_d;
    ln_q   <= ln_d;
    qa_q   <= qa_d;
    q_q    <= q_d;
    stat_q <= stat_d;
    slot_q <= slot_d;
    if (out_load) begin
      out_status_q <= stat_q;
      out_slot_q   <= slot_q;
      out_pred_q   <= idx_q;
      out_cnt_q    <= cnt_q;
    end
  end

  always_comb begin
    state_d       = state_q;
    mode_d        = mode_q;
    key_d         = key_q;
    cnt_d         = cnt_q;
    idx_d         = idx_q;
    nx_d          = nx_q;
    lp_d          = lp_q;
    hit_d         = hit_q;
    kn_d          = kn_q;
    ln_d          = ln_q;
    qa_d          = qa_q;
    q_d           = q_q;
    stat_d        = stat_q;
    slot_d        = slot_q;
    ctl           = '0;
    raddr         = nx_q;
    waddr         = idx_q;
    nxt_wdata     = lp_q;
    key_wdata     = key_q;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    m_valid_d     = m_valid_q && !m_axis_tready;

    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          mode_d  = s_axis_tdata[MODE_W-1:0];
          key_d   = s_axis_tdata[MODE_W +: KEY_WIDTH];
          state_d = S_START;
        end
      end
      S_START: begin
        idx_d  = '0;
        nx_d   = head;
        hit_d  = 1'b0;
        slot_d = '0;
        stat_d = ST_OK;
        if (CmpW'(key_q) >= CmpW'(tail_q)) begin
          stat_d  = ST_RANGE;
          state_d = S_EMIT;
        end else if ((mode_q == MODE_INSERT) && (cnt_q == MaxCnt)) begin
          stat_d  = ST_FULL;
          state_d = S_EMIT;
        end else if ((mode_q == MODE_DELETE) && (cnt_q == '0)) begin
          stat_d  = ST_NOT_FOUND;
          state_d = S_EMIT;
        end else if (head == '0) begin
          state_d = S_ACT;
        end else begin
          ctl.rd_en = 1'b1;
          raddr     = head;
          state_d   = S_WALK;
        end
      end
      S_WALK: begin
        // read data belongs to slot nx_q
        if (key_rdata >= key_q) begin
          hit_d   = (key_rdata == key_q);
          lp_d    = nxt_rdata;
          state_d = S_ACT;
        end else begin
          idx_d = nx_q;
          nx_d  = nxt_rdata;
          if (nxt_rdata == '0) begin
            state_d = S_ACT;
          end else begin
            ctl.rd_en = 1'b1;
            raddr     = nxt_rdata;
          end
        end
      end
      S_ACT: begin
        case (mode_q)
          MODE_INSERT: begin
            if (hit_q) begin
              stat_d  = ST_DUPLICATE;
              slot_d  = nx_q;
              state_d = S_EMIT;
            end else begin
              ctl.key_we = 1'b1;
              ctl.nxt_we = 1'b1;
              waddr      = cnt_inc;
              nxt_wdata  = nx_q;
              state_d    = S_INS_LINK;
            end
          end
          MODE_DELETE: begin
            if (!hit_q) begin
              stat_d  = ST_NOT_FOUND;
              state_d = S_EMIT;
            end else if (nx_q == cnt_q) begin
              // deleting the last slot: just unlink it
              ctl.nxt_we = 1'b1;
              cnt_d      = cnt_q - SlotW'(1);
              state_d    = S_EMIT;
            end else begin
              ctl.rd_en = 1'b1;
              raddr     = cnt_q;
              state_d   = S_DEL_RDN;
            end
          end
          default: begin
            if (hit_q) begin
              slot_d = nx_q;
            end else begin
              stat_d = ST_NOT_FOUND;
            end
            state_d = S_EMIT;
          end
        endcase
      end
      S_INS_LINK: begin
        ctl.nxt_we = 1'b1;
        nxt_wdata  = cnt_inc;
        cnt_d      = cnt_inc;
        slot_d     = cnt_inc;
        state_d    = S_EMIT;
      end
      S_DEL_RDN: begin
        kn_d = key_rdata;
        // if the predecessor is the last slot, its link is rewritten to lp first
        ln_d = (idx_q == cnt_q) ? lp_q : nxt_rdata;
        if (lp_q == cnt_q) begin
          state_d = S_DEL_WP;
        end else if (head == cnt_q) begin
          q_d     = '0;
          state_d = S_DEL_WQ;
        end else begin
          qa_d      = head;
          ctl.rd_en = 1'b1;
          raddr     = head;
          state_d   = S_DEL_FINDQ;
        end
      end
      S_DEL_FINDQ: begin
        if (nxt_rdata == cnt_q) begin
          q_d     = qa_q;
          state_d = S_DEL_WQ;
        end else begin
          qa_d      = nxt_rdata;
          ctl.rd_en = 1'b1;
          raddr     = nxt_rdata;
        end
      end
      S_DEL_WQ: begin
        ctl.nxt_we = 1'b1;
        waddr      = q_q;
        nxt_wdata  = nx_q;
        state_d    = S_DEL_WPRED;
      end
      S_DEL_WPRED: begin
        ctl.nxt_we = 1'b1;
        state_d    = S_DEL_WP;
      end
      S_DEL_WP: begin
        // move the last slot into the hole
        ctl.key_we = 1'b1;
        ctl.nxt_we = 1'b1;
        waddr      = nx_q;
        key_wdata  = kn_q;
        nxt_wdata  = ln_q;
        cnt_d      = cnt_q - SlotW'(1);
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load  = 1'b1;
          m_valid_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OutTdataW'({out_cnt_q, out_pred_q, out_slot_q, out_status_q});

endmodule

@@ design/sls_store.sv @@
// Key and link memories of the sorted set, with the head link in a register.
module sls_store
  import sls_pkg::*;
#(
  parameter int MAX_ENTRIES = 128,
  parameter int KEY_WIDTH   = 16,
  localparam int Depth      = MAX_ENTRIES + 1,
  localparam int SlotW      = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  store_ctl_t           ctl_i,
  input  logic [SlotW-1:0]     raddr_i,
  input  logic [SlotW-1:0]     waddr_i,
  input  logic [KEY_WIDTH-1:0] key_wdata_i,
  input  logic [SlotW-1:0]     nxt_wdata_i,
  output logic [KEY_WIDTH-1:0] key_rdata_o,
  output logic [SlotW-1:0]     nxt_rdata_o,
  output logic [SlotW-1:0]     head_o
);

  logic [KEY_WIDTH-1:0] key_mem [Depth];
  logic [SlotW-1:0]     nxt_mem [Depth];
  logic [KEY_WIDTH-1:0] key_rd_q;
  logic [SlotW-1:0]     nxt_rd_q;
  logic [SlotW-1:0]     head_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.key_we) begin
      key_mem[waddr_i] <= key_wdata_i;
    end
    if (ctl_i.rd_en) begin
      key_rd_q <= key_mem[raddr_i];
    end
  end

  // Slot 0 link lives in head_q; its memory entry is never read.
  always_ff @(posedge clk_i) begin
    if (ctl_i.nxt_we && (waddr_i != '0)) begin
      nxt_mem[waddr_i] <= nxt_wdata_i;
    end
    if (ctl_i.rd_en) begin
      nxt_rd_q <= nxt_mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else if (ctl_i.nxt_we && (waddr_i == '0)) begin
      head_q <= nxt_wdata_i;
    end
  end

  assign key_rdata_o = key_rd_q;
  assign nxt_rdata_o = nxt_rd_q;
  assign head_o      = head_q;

endmodule

@@ design/sls_checker.sv @@
// Port-level checks of the sorted set, bound to the top level.
`include "sorted_linked_list_set_assert.svh"

module sls_checker
  import sls_pkg::*;
#(
  parameter int MAX_ENTRIES = 128,
  parameter int KEY_WIDTH   = 16,
  localparam int SlotW      = $clog2(MAX_ENTRIES + 1),
  localparam int OutTdataW  = ((STATUS_W + 3 * SlotW + 7) / 8) * 8
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata
);

  logic [STATUS_W-1:0] status;
  logic [SlotW-1:0]    slot;
  logic [SlotW-1:0]    count;

  assign status = m_axis_tdata[STATUS_W-1:0];
  assign slot   = m_axis_tdata[STATUS_W +: SlotW];
  assign count  = m_axis_tdata[STATUS_W + 2 * SlotW +: SlotW];

  `SLS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `SLS_ASSERT_NEXT(a_data_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `SLS_ASSERT_NEXT(a_one_item, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `SLS_ASSERT_SAME(a_slot_in_use, clk_i, rst_ni, m_axis_tvalid && (status == ST_OK) && (slot != '0), (slot <= count))

endmodule

bind sorted_linked_list_set sls_checker #(
  .MAX_ENTRIES(MAX_ENTRIES),
  .KEY_WIDTH  (KEY_WIDTH)
) u_sls_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
